FILE: rtl/ts_video_packetizer_defines.svh
// Assertion macros for the transport stream packetizer.
// Used by the top level; no other dependencies.
`ifndef TS_VIDEO_PACKETIZER_DEFINES_SVH
`define TS_VIDEO_PACKETIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSVP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tsvp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSVP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tsvp assertion failed");

`endif

FILE: rtl/tsvp_pkg.sv
// Shared types, constants and byte tables of the transport stream packetizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tsvp_pkg;

    localparam int PACKET_SIZE  = 188;
    localparam int PAYLOAD_MAX  = PACKET_SIZE - 4;
    localparam int KEY_FIRST_MAX = PAYLOAD_MAX - 2;
    localparam int PES_HDR_LEN  = 14;
    localparam int PAT_LEN      = 17;
    localparam int PMT_LEN      = 22;
    localparam int PAT_SEC_END  = 13;
    localparam int PMT_SEC_END  = 18;
    localparam int BUF_AW       = $clog2(PAYLOAD_MAX);
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [1:0] REG_VIDEO_PID = 2'd0;
    localparam logic [1:0] REG_PMT_PID   = 2'd1;
    localparam logic [1:0] REG_PROGRAM   = 2'd2;
    localparam logic [1:0] REG_STREAM    = 2'd3;

    localparam logic CMD_TABLES = 1'b0;
    localparam logic CMD_VIDEO  = 1'b1;

    typedef enum logic [1:0] {
        ROLE_PAT,
        ROLE_PMT,
        ROLE_VIDEO
    } role_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAT,
        ST_PMT,
        ST_FLUSH,
        ST_BYTE
    } state_t;

    typedef struct packed {
        logic        start;
        role_t       role;
        logic        pusi;
        logic        rai;
        logic [7:0]  len;
        logic        last_pkt;
    } pkt_req_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        logic        pkt_end;
        logic        last_pkt;
    } byte_strm_t;

    typedef struct packed {
        logic [12:0] vid_pid;
        logic [12:0] pmt_pid;
        logic [15:0] program_number;
        logic [7:0]  stream_type;
    } cfg_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] pat_byte(input logic [4:0] d, input cfg_t cfg);
        logic [7:0] b;
        unique case (d)
            5'd2:    b = 8'hB0;
            5'd3:    b = 8'h0D;
            5'd5:    b = 8'h01;
            5'd6:    b = 8'hC1;
            5'd9:    b = cfg.program_number[15:8];
            5'd10:   b = cfg.program_number[7:0];
            5'd11:   b = {3'b111, cfg.pmt_pid[12:8]};
            5'd12:   b = cfg.pmt_pid[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pmt_byte(input logic [4:0] d, input cfg_t cfg);
        logic [7:0] b;
        unique case (d)
            5'd1:    b = 8'h02;
            5'd2:    b = 8'hB0;
            5'd3:    b = 8'h12;
            5'd4:    b = cfg.program_number[15:8];
            5'd5:    b = cfg.program_number[7:0];
            5'd6:    b = 8'hC1;
            5'd9:    b = {3'b111, cfg.vid_pid[12:8]};
            5'd10:   b = cfg.vid_pid[7:0];
            5'd11:   b = 8'hF0;
            5'd13:   b = cfg.stream_type;
            5'd14:   b = {3'b111, cfg.vid_pid[12:8]};
            5'd15:   b = cfg.vid_pid[7:0];
            5'd16:   b = 8'hF0;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pes_byte(input logic [3:0] d, input logic [32:0] pts);
        logic [7:0] b;
        unique case (d)
            4'd2:    b = 8'h01;
            4'd3:    b = 8'hE0;
            4'd6:    b = 8'h80;
            4'd7:    b = 8'h80;
            4'd8:    b = 8'h05;
            4'd9:    b = {4'b0010, pts[32:30], 1'b1};
            4'd10:   b = pts[29:22];
            4'd11:   b = {pts[21:15], 1'b1};
            4'd12:   b = pts[14:7];
            4'd13:   b = {pts[6:0], 1'b1};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tsvp_buf.sv
// Payload byte buffer: one write port, one registered read port.
// Depends on tsvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsvp_buf
    import tsvp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [BUF_AW-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [BUF_AW-1:0] raddr,
    output logic [7:0]             rdata
);

    logic [7:0] mem [PAYLOAD_MAX];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/tsvp_gen.sv
// Packet byte generator: walks the 188 byte positions of one packet, builds
// header, adaptation field, tables with CRC and PES header, reads payload.
// Depends on tsvp_pkg and drives the read port of tsvp_buf.
`timescale 1ns / 1ps
`default_nettype none

module tsvp_gen
    import tsvp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pkt_req_t          req,
    input  wire cfg_t              cfg,
    input  wire logic [32:0]       held_pts,
    output logic                   busy,
    output byte_strm_t             strm,
    input  wire logic              strm_ready,
    output logic                   mem_re,
    output logic [BUF_AW-1:0]      mem_raddr,
    input  wire logic [7:0]        mem_rdata
);

    logic        busy_reg;
    logic [7:0]  pos_reg;
    role_t       role_reg;
    logic        pusi_reg, rai_reg, last_pkt_reg;
    logic [7:0]  len_reg;
    logic [12:0] pid_reg;
    logic [31:0] crc_reg, crc_next;
    logic [3:0]  cc_reg [3];

    logic        s2_valid_reg, s2_mem_reg, s2_end_reg, s2_last_reg;
    logic [7:0]  s2_byte_reg;

    logic        advance, fire;
    logic [7:0]  dstart, didx, stuff, b1;
    logic        in_data, use_mem, has_af;
    logic [3:0]  cur_cc;
    logic [4:0]  crc_sel;

    assign advance = !s2_valid_reg || strm_ready;
    assign fire    = busy_reg && advance;
    assign stuff   = 8'(PAYLOAD_MAX) - len_reg;
    assign has_af  = (stuff != 8'd0);
    assign dstart  = 8'(PACKET_SIZE) - len_reg;
    assign in_data = (pos_reg >= dstart);
    assign didx    = pos_reg - dstart;

    always_comb begin
        unique case (role_reg)
            ROLE_PAT:   cur_cc = cc_reg[0];
            ROLE_PMT:   cur_cc = cc_reg[1];
            ROLE_VIDEO: cur_cc = cc_reg[2];
            default:    cur_cc = 4'h0;
        endcase
    end

    // stage 1: byte for the current position
    always_comb begin
        b1       = 8'hFF;
        use_mem  = 1'b0;
        crc_next = crc_reg;
        crc_sel  = 5'd0;
        if (pos_reg == 8'd0) begin
            b1 = 8'h47;
        end else if (pos_reg == 8'd1) begin
            b1 = {1'b0, pusi_reg, 1'b0, pid_reg[12:8]};
        end else if (pos_reg == 8'd2) begin
            b1 = pid_reg[7:0];
        end else if (pos_reg == 8'd3) begin
            b1 = {2'b00, has_af, 1'b1, cur_cc};
        end else if (in_data) begin
            unique case (role_reg)
                ROLE_PAT: begin
                    if (didx < 8'(PAT_SEC_END)) begin
                        b1 = pat_byte(didx[4:0], cfg);
                        if (didx != 8'd0) crc_next = crc_byte(crc_reg, b1);
                    end else begin
                        crc_sel = didx[4:0] - 5'(PAT_SEC_END);
                    end
                end
                ROLE_PMT: begin
                    if (didx < 8'(PMT_SEC_END)) begin
                        b1 = pmt_byte(didx[4:0], cfg);
                        if (didx != 8'd0) crc_next = crc_byte(crc_reg, b1);
                    end else begin
                        crc_sel = didx[4:0] - 5'(PMT_SEC_END);
                    end
                end
                default: begin
                    if (pusi_reg && didx < 8'(PES_HDR_LEN)) begin
                        b1 = pes_byte(didx[3:0], held_pts);
                    end else begin
                        use_mem = 1'b1;
                    end
                end
            endcase
            if (role_reg != ROLE_VIDEO && didx >= 8'(PAT_SEC_END)
                && !(role_reg == ROLE_PMT && didx < 8'(PMT_SEC_END))) begin
                unique case (crc_sel[1:0])
                    2'd0: b1 = crc_reg[31:24];
                    2'd1: b1 = crc_reg[23:16];
                    2'd2: b1 = crc_reg[15:8];
                    2'd3: b1 = crc_reg[7:0];
                endcase
            end
        end else if (pos_reg == 8'd4) begin
            b1 = stuff - 8'd1;
        end else if (pos_reg == 8'd5) begin
            b1 = rai_reg ? 8'h40 : 8'h00;
        end
    end

    assign mem_re    = fire && use_mem;
    assign mem_raddr = didx[BUF_AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            s2_valid_reg <= 1'b0;
            cc_reg[0]    <= 4'h0;
            cc_reg[1]    <= 4'h0;
            cc_reg[2]    <= 4'h0;
        end else begin
            if (req.start && !busy_reg) begin
                busy_reg     <= 1'b1;
                pos_reg      <= 8'd0;
                role_reg     <= req.role;
                pusi_reg     <= req.pusi;
                rai_reg      <= req.rai;
                len_reg      <= req.len;
                last_pkt_reg <= req.last_pkt;
                crc_reg      <= CRC_INIT;
                unique case (req.role)
                    ROLE_PAT:   pid_reg <= 13'h0;
                    ROLE_PMT:   pid_reg <= cfg.pmt_pid;
                    default:    pid_reg <= cfg.vid_pid;
                endcase
            end
            if (fire) begin
                s2_valid_reg <= 1'b1;
                s2_byte_reg  <= b1;
                s2_mem_reg   <= use_mem;
                s2_end_reg   <= (pos_reg == 8'(PACKET_SIZE - 1));
                s2_last_reg  <= last_pkt_reg;
                crc_reg      <= crc_next;
                pos_reg      <= pos_reg + 8'd1;
                if (pos_reg == 8'(PACKET_SIZE - 1)) begin
                    busy_reg <= 1'b0;
                    unique case (role_reg)
                        ROLE_PAT:   cc_reg[0] <= cc_reg[0] + 4'd1;
                        ROLE_PMT:   cc_reg[1] <= cc_reg[1] + 4'd1;
                        default:    cc_reg[2] <= cc_reg[2] + 4'd1;
                    endcase
                end
            end else if (advance) begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    assign busy          = busy_reg;
    assign strm.valid    = s2_valid_reg;
    assign strm.data     = s2_mem_reg ? mem_rdata : s2_byte_reg;
    assign strm.pkt_end  = s2_end_reg;
    assign strm.last_pkt = s2_last_reg;

endmodule

`default_nettype wire

FILE: rtl/tsvp_pack.sv
// Word packer: gathers packet bytes into 64-bit words, earliest byte on top,
// and holds each finished word in the output register.
// Depends on tsvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsvp_pack
    import tsvp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire byte_strm_t strm,
    output logic            strm_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [63:0]     m_word,
    output logic [3:0]      m_nbytes,
    output logic            m_pkt_end,
    output logic            m_last
);

    logic [63:0] acc_reg;
    logic [2:0]  cnt_reg;
    logic        m_valid_reg;
    logic [63:0] word_reg;
    logic [3:0]  nbytes_reg;
    logic        pkt_end_reg, last_reg;

    logic        complete, out_free, take;
    logic [63:0] merged;

    assign complete   = strm.pkt_end || (cnt_reg == 3'd7);
    assign out_free   = !m_valid_reg || m_ready;
    assign strm_ready = !complete || out_free;
    assign take       = strm.valid && strm_ready;
    assign merged     = acc_reg | ({56'h0, strm.data} << {3'(3'd7 - cnt_reg), 3'b000});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= 3'd0;
            acc_reg     <= 64'h0;
        end else begin
            if (m_ready && !(take && complete)) m_valid_reg <= 1'b0;
            if (take) begin
                if (complete) begin
                    word_reg    <= merged;
                    nbytes_reg  <= {1'b0, cnt_reg} + 4'd1;
                    pkt_end_reg <= strm.pkt_end;
                    last_reg    <= strm.pkt_end && strm.last_pkt;
                    m_valid_reg <= 1'b1;
                    acc_reg     <= 64'h0;
                    cnt_reg     <= 3'd0;
                end else begin
                    acc_reg <= merged;
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_word    = word_reg;
    assign m_nbytes  = nbytes_reg;
    assign m_pkt_end = pkt_end_reg;
    assign m_last    = last_reg;

endmodule

`default_nettype wire

FILE: rtl/ts_video_packetizer.sv
// One packet byte per cycle unless the output stalls, 188 bytes a packet, and the input waits
// for it: a table command, a frame start that flushes and a byte that sends a packet each hold
// off the next transfer until their packets are sent; a byte that only buffers, while it is written.
// Reset (aresetn, synchronous, active low) clears control state and counters and
// loads the configuration defaults; the payload buffer needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "ts_video_packetizer_defines.svh"

module ts_video_packetizer
    import tsvp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] data_byte, [8] first_of_frame, [41:9] pts, [42] keyframe
    input  wire logic [47:0] s_tdata,
    // [0] cmd
    input  wire logic        s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [63:0] out_word, [67:64] valid_bytes
    output logic [71:0]      m_tdata,
    // [0] packet_end
    output logic             m_tuser,
    output logic             m_tlast
);

    cfg_t        cfg_reg;
    state_t      state_reg, state_next;
    logic [7:0]  fill_reg;
    logic [32:0] held_pts_reg;
    logic        held_key_reg, in_first_reg;
    logic [7:0]  item_byte_reg;
    logic        item_first_reg, item_last_reg, item_key_reg;
    logic [32:0] item_pts_reg;

    pkt_req_t    req;
    byte_strm_t  strm;
    logic        gen_busy, strm_ready, mem_re, mem_we;
    logic [BUF_AW-1:0] mem_raddr;
    logic [7:0]  mem_rdata;
    logic        accept;
    logic [7:0]  fill_eff, fill_new, cap;
    logic        first_eff, key_eff, send;
    logic [63:0] word;
    logic [3:0]  nbytes;

    assign accept    = s_tvalid && s_tready;
    assign fill_eff  = item_first_reg ? 8'(PES_HDR_LEN) : fill_reg;
    assign first_eff = item_first_reg || in_first_reg;
    assign key_eff   = item_first_reg ? item_key_reg : held_key_reg;
    assign cap       = (first_eff && key_eff) ? 8'(KEY_FIRST_MAX) : 8'(PAYLOAD_MAX);
    assign fill_new  = fill_eff + 8'd1;
    assign send      = (fill_new >= cap) || item_last_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == CMD_TABLES) begin
                        state_next = ST_PAT;
                    end else if (s_tdata[8] && fill_reg != 8'd0) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_BYTE;
                    end
                end
            end
            ST_PAT:   state_next = ST_PMT;
            ST_PMT:   if (!gen_busy) state_next = ST_IDLE;
            ST_FLUSH: state_next = ST_BYTE;
            ST_BYTE:  if (!gen_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        mem_we       = 1'b0;
        req.start    = 1'b0;
        req.role     = ROLE_VIDEO;
        req.pusi     = 1'b1;
        req.rai      = 1'b0;
        req.len      = 8'(PAT_LEN);
        req.last_pkt = 1'b1;
        unique case (state_reg)
            ST_IDLE: s_tready = !gen_busy;
            ST_PAT: begin
                req.start    = 1'b1;
                req.role     = ROLE_PAT;
                req.last_pkt = 1'b0;
            end
            ST_PMT: begin
                req.start = !gen_busy;
                req.role  = ROLE_PMT;
                req.len   = 8'(PMT_LEN);
            end
            ST_FLUSH: begin
                req.start    = 1'b1;
                req.pusi     = in_first_reg;
                req.rai      = in_first_reg && held_key_reg;
                req.len      = fill_reg;
                req.last_pkt = !item_last_reg;
            end
            ST_BYTE: begin
                mem_we    = !gen_busy;
                req.start = !gen_busy && send;
                req.pusi  = first_eff;
                req.rai   = first_eff && key_eff;
                req.len   = fill_new;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= 8'd0;
            held_pts_reg   <= 33'h0;
            held_key_reg   <= 1'b0;
            in_first_reg   <= 1'b0;
            cfg_reg.vid_pid        <= 13'd256;
            cfg_reg.pmt_pid        <= 13'd4096;
            cfg_reg.program_number <= 16'd1;
            cfg_reg.stream_type    <= 8'h1B;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_VIDEO_PID: cfg_reg.vid_pid        <= cfg_wdata[12:0];
                    REG_PMT_PID:   cfg_reg.pmt_pid        <= cfg_wdata[12:0];
                    REG_PROGRAM:   cfg_reg.program_number <= cfg_wdata;
                    REG_STREAM:    cfg_reg.stream_type    <= cfg_wdata[7:0];
                endcase
            end
            if (state_reg == ST_FLUSH) begin
                fill_reg     <= 8'd0;
                in_first_reg <= 1'b0;
            end
            if (mem_we) begin
                if (item_first_reg) begin
                    held_pts_reg <= item_pts_reg;
                    held_key_reg <= item_key_reg;
                end
                fill_reg     <= send ? 8'd0 : fill_new;
                in_first_reg <= send ? 1'b0 : first_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_byte_reg  <= s_tdata[7:0];
            item_first_reg <= s_tdata[8];
            item_pts_reg   <= s_tdata[41:9];
            item_key_reg   <= s_tdata[42];
            item_last_reg  <= s_tlast;
        end
    end

    tsvp_buf u_buf (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (fill_eff[BUF_AW-1:0]),
        .wdata (item_byte_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tsvp_gen u_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .cfg        (cfg_reg),
        .held_pts   (held_pts_reg),
        .busy       (gen_busy),
        .strm       (strm),
        .strm_ready (strm_ready),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tsvp_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .strm       (strm),
        .strm_ready (strm_ready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_word     (word),
        .m_nbytes   (nbytes),
        .m_pkt_end  (m_tuser),
        .m_last     (m_tlast)
    );

    assign m_tdata = {4'h0, nbytes, word};

    `TSVP_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= 8'(PAYLOAD_MAX))
    `TSVP_ASSERT_NOW(a_start_idle, aclk, aresetn, req.start, !gen_busy)
    `TSVP_ASSERT_NOW(a_end_short, aclk, aresetn, m_tvalid && m_tuser, nbytes == 4'd4)
    `TSVP_ASSERT_NOW(a_first_fill, aclk, aresetn,
        state_reg == ST_IDLE && in_first_reg, fill_reg > 8'(PES_HDR_LEN))

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking bench for ts_video_packetizer: PAT/PMT and video packet framing.
// Scoreboard class predicts 64-bit output words; depends on tsvp_pkg and the RTL.
`timescale 1ns / 1ps

import tsvp_pkg::*;

typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        pkt_end;
    logic        run_end;
} ts_word_t;

class PacketScoreboard;
    bit [12:0] vpid;
    bit [12:0] ppid;
    bit [15:0] prog;
    bit [7:0]  stype;
    bit [7:0]  payload[PAYLOAD_MAX];
    int        fill;
    bit [3:0]  cc[3];
    bit [32:0] pts_held;
    bit        key_held;
    bit        first_pkt;
    ts_word_t  words_due[$];
    int        errors;

    function void reset_state();
        vpid = 13'd256;
        ppid = 13'd4096;
        prog = 16'd1;
        stype = 8'h1B;
        fill = 0;
        foreach (cc[i]) cc[i] = 4'd0;
        pts_held = '0;
        key_held = 1'b0;
        first_pkt = 1'b0;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [15:0] value);
        case (addr)
            REG_VIDEO_PID: vpid = value[12:0];
            REG_PMT_PID:   ppid = value[12:0];
            REG_PROGRAM:   prog = value;
            REG_STREAM:    stype = value[7:0];
        endcase
    endfunction

    function bit [31:0] section_crc(bit [7:0] sec[32], int n);
        bit [31:0] c;
        c = 32'hFFFF_FFFF;
        for (int i = 1; i <= n; i++) begin
            c ^= {sec[i], 24'h0};
            for (int b = 0; b < 8; b++)
                c = c[31] ? ((c << 1) ^ 32'h04C1_1DB7) : (c << 1);
        end
        return c;
    endfunction

    // Frame one packet and queue its 24 words.
    function void emit_packet(int role, bit [12:0] pid, bit pusi, bit rai,
                              bit [7:0] data[PAYLOAD_MAX], int len);
        bit [7:0] p[PACKET_SIZE];
        ts_word_t w;
        int stuff, pos, af;
        stuff = PAYLOAD_MAX - len;
        foreach (p[i]) p[i] = 8'hFF;
        p[0] = 8'h47;
        p[1] = {1'b0, pusi, 1'b0, pid[12:8]};
        p[2] = pid[7:0];
        p[3] = {(stuff > 0) ? 4'h3 : 4'h1, cc[role]};
        cc[role] = cc[role] + 4'd1;
        pos = 4;
        if (stuff > 0) begin
            af = stuff - 1;
            p[4] = af[7:0];
            pos = 5;
            if (af > 0) begin
                p[5] = rai ? 8'h40 : 8'h00;
                pos = 5 + af;
            end
        end
        for (int i = 0; i < len; i++) p[pos + i] = data[i];
        for (int k = 0; k < 24; k++) begin
            w.nbytes = (k < 23) ? 4'd8 : 4'd4;
            w.word = '0;
            for (int b = 0; b < w.nbytes; b++) w.word[63 - 8*b -: 8] = p[k*8 + b];
            w.pkt_end = (k == 23);
            w.run_end = 1'b0;
            words_due.push_back(w);
        end
    endfunction

    function void flush_video();
        emit_packet(int'(ROLE_VIDEO), vpid, first_pkt, first_pkt && key_held, payload, fill);
        fill = 0;
        first_pkt = 1'b0;
    endfunction

    function void emit_tables();
        bit [7:0] sec[32];
        bit [7:0] d[PAYLOAD_MAX];
        bit [31:0] c;
        foreach (sec[i]) sec[i] = 8'h00;
        sec[2] = 8'hB0; sec[3] = 8'h0D; sec[5] = 8'h01; sec[6] = 8'hC1;
        sec[9] = prog[15:8]; sec[10] = prog[7:0];
        sec[11] = {3'b111, ppid[12:8]}; sec[12] = ppid[7:0];
        c = section_crc(sec, 12);
        {sec[13], sec[14], sec[15], sec[16]} = c;
        for (int i = 0; i < 17; i++) d[i] = sec[i];
        emit_packet(int'(ROLE_PAT), 13'd0, 1'b1, 1'b0, d, 17);

        foreach (sec[i]) sec[i] = 8'h00;
        sec[1] = 8'h02; sec[2] = 8'hB0; sec[3] = 8'h12;
        sec[4] = prog[15:8]; sec[5] = prog[7:0]; sec[6] = 8'hC1;
        sec[9] = {3'b111, vpid[12:8]}; sec[10] = vpid[7:0];
        sec[11] = 8'hF0; sec[13] = stype;
        sec[14] = {3'b111, vpid[12:8]}; sec[15] = vpid[7:0]; sec[16] = 8'hF0;
        c = section_crc(sec, 17);
        {sec[18], sec[19], sec[20], sec[21]} = c;
        for (int i = 0; i < 22; i++) d[i] = sec[i];
        emit_packet(int'(ROLE_PMT), ppid, 1'b1, 1'b0, d, 22);
    endfunction

    function void note_input(logic cmd, logic [7:0] b, logic first, logic last,
                             logic [32:0] pts, logic key);
        int n0, cap;
        n0 = words_due.size();
        if (cmd == CMD_TABLES) begin
            emit_tables();
        end else begin
            if (first) begin
                if (fill > 0) flush_video();
                pts_held = pts;
                key_held = key;
                first_pkt = 1'b1;
                payload[0] = 8'h00; payload[1] = 8'h00; payload[2] = 8'h01;
                payload[3] = 8'hE0; payload[4] = 8'h00; payload[5] = 8'h00;
                payload[6] = 8'h80; payload[7] = 8'h80; payload[8] = 8'h05;
                payload[9]  = {4'b0010, pts_held[32:30], 1'b1};
                payload[10] = pts_held[29:22];
                payload[11] = {pts_held[21:15], 1'b1};
                payload[12] = pts_held[14:7];
                payload[13] = {pts_held[6:0], 1'b1};
                fill = PES_HDR_LEN;
            end
            cap = (first_pkt && key_held) ? KEY_FIRST_MAX : PAYLOAD_MAX;
            if (fill < PAYLOAD_MAX) begin
                payload[fill] = b;
                fill++;
            end
            if (fill >= cap || last) flush_video();
        end
        if (words_due.size() > n0) words_due[$].run_end = 1'b1;
    endfunction

    function void check_word(logic [63:0] word, logic [3:0] nb, logic pend, logic lor);
        ts_word_t e;
        if (words_due.size() == 0) begin
            $display("%0t: unexpected word %h nb=%0d end=%b last=%b", $time, word, nb, pend, lor);
            errors++;
            return;
        end
        e = words_due.pop_front();
        if (word !== e.word) begin
            $display("%0t: out_word exp %h got %h", $time, e.word, word);
            errors++;
        end
        if (nb !== e.nbytes) begin
            $display("%0t: valid_bytes exp %0d got %0d", $time, e.nbytes, nb);
            errors++;
        end
        if (pend !== e.pkt_end) begin
            $display("%0t: packet_end exp %b got %b", $time, e.pkt_end, pend);
            errors++;
        end
        if (lor !== e.run_end) begin
            $display("%0t: last_of_run exp %b got %b", $time, e.run_end, lor);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    PacketScoreboard sb;
    int idle_pct;
    int stall_pct;
    int n_items;
    int quiet;

    ts_video_packetizer dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata[63:0], m_tdata[67:64], m_tuser, m_tlast);
        if ((aresetn && m_tvalid && m_tready) || (s_tvalid && s_tready) || !aresetn)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send(logic cmd, logic [7:0] b, logic first, logic last,
                        logic [32:0] pts, logic key);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= last;
        s_tdata  <= {5'b0, key, pts, first, b};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, b, first, last, pts, key);
        n_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.words_due.size() != 0) @(posedge aclk);
        // byte-only transfers leave no result; let the write port settle
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_regs(logic [15:0] v, logic [15:0] p, logic [15:0] g, logic [15:0] s);
        logic [15:0] vals[4];
        logic [1:0] addrs[4];
        vals = '{v, p, g, s};
        addrs = '{REG_VIDEO_PID, REG_PMT_PID, REG_PROGRAM, REG_STREAM};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(addrs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [32:0] rand_pts();
        return {1'($urandom_range(1, 0)), $urandom()};
    endfunction

    // Short frame, cut off once the phase has sent its share of items.
    task automatic random_frame(int stop_at);
        int len;
        bit key, broken;
        logic [32:0] pts;
        len = $urandom_range(30, 1);
        key = 1'($urandom_range(1, 0));
        broken = ($urandom_range(9) == 0);
        pts = rand_pts();
        for (int i = 0; i < len && n_items < stop_at; i++) begin
            if ($urandom_range(199) == 0)
                send(CMD_TABLES, 8'($urandom()), 1'b0, 1'b0, rand_pts(), 1'b0);
            send(CMD_VIDEO, 8'($urandom()), i == 0, (i == len - 1) && !broken,
                 (i == 0) ? pts : rand_pts(), (i == 0) ? key : 1'($urandom_range(1, 0)));
        end
    endtask

    initial begin
        int r, goal;
        sb = new();
        sb.reset_state();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        n_items = 0;
        quiet = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, stray bytes, pts extremes, keyframes, tables mid-frame
        send(CMD_TABLES, 8'h00, 0, 0, '0, 0);
        send(CMD_VIDEO, 8'h00, 0, 0, '0, 0);
        send(CMD_VIDEO, 8'hFF, 0, 1, '1, 1);
        send(CMD_VIDEO, 8'hA5, 1, 1, '0, 0);
        send(CMD_VIDEO, 8'h5A, 1, 1, '1, 1);
        send(CMD_VIDEO, 8'h11, 1, 0, 33'h1_2345_6789, 1);
        send(CMD_VIDEO, 8'h22, 0, 0, '0, 0);
        send(CMD_TABLES, 8'hFF, 1, 1, '1, 1);
        send(CMD_VIDEO, 8'h33, 1, 0, 33'h0_AAAA_5555, 0);
        send(CMD_VIDEO, 8'h44, 0, 1, '0, 0);
        drain();

        // long frames: keyframe fills its short first packet, plain frame a full one
        for (int i = 0; i < 170; i++)
            send(CMD_VIDEO, 8'(i), i == 0, i == 169, 33'h1_0000_0001, 1'b1);
        for (int i = 0; i < 171; i++)
            send(CMD_VIDEO, 8'(i + 7), i == 0, i == 170, 33'h0_1234_5678, 1'b0);
        drain();

        write_regs(16'd0, 16'd0, 16'd0, 16'd0);
        send(CMD_TABLES, 8'h00, 0, 0, '0, 0);
        send(CMD_VIDEO, 8'h01, 1, 1, '0, 1);
        drain();
        write_regs(16'h1FFF, 16'h1FFF, 16'hFFFF, 16'hFF);
        send(CMD_TABLES, 8'h00, 0, 0, '0, 0);
        send(CMD_VIDEO, 8'h02, 1, 1, '1, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                3: begin idle_pct = 9;  stall_pct = 9;  end
            endcase
            case (ph)
                0: write_regs(16'd256, 16'd4096, 16'd1, 16'h1B);
                4: write_regs(16'h1FFF, 16'd0, 16'hFFFF, 16'd0);
                default: write_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                    16'($urandom()));
            endcase
            goal = n_items + 16;
            while (n_items < goal) begin
                r = $urandom_range(99);
                if (r < 4)
                    send(CMD_TABLES, 8'($urandom()), 1'($urandom_range(1, 0)),
                         1'($urandom_range(1, 0)), rand_pts(), 1'($urandom_range(1, 0)));
                else if (r < 14)
                    send(CMD_VIDEO, 8'($urandom()), 1'($urandom_range(1, 0)),
                         1'($urandom_range(1, 0)), rand_pts(), 1'($urandom_range(1, 0)));
                else
                    random_frame(goal);
            end
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
